// ===== design/route_entry_table_unit_macros.svh =====
// Assertion macros shared by the route entry table RTL.
// Included by route_entry_table_unit.sv; expects a clock clk and reset rst_n in scope.
`ifndef ROUTE_ENTRY_TABLE_UNIT_MACROS_SVH
`define ROUTE_ENTRY_TABLE_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define RETE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication from one cycle into the next.
`define RETE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/rete_pkg.sv =====
// Shared types and constants of the route entry table.
// No dependencies; used by the interfaces and all modules.
`timescale 1ns / 1ps

package rete_pkg;

  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;
  localparam int KEY_W    = 16;
  localparam int ADDR_W   = 32;
  localparam int PLEN_W   = 6;
  localparam int IFACE_W  = 8;
  localparam int PAY_W    = 2 * ADDR_W + PLEN_W + IFACE_W;

  localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd4;

  // Outcome flags of one pass over the slot tags.
  typedef struct packed {
    logic free_found;
    logic hit_found;
  } scan_flags_t;

endpackage

// ===== design/rete_if.sv =====
// Request and response channel interfaces of the route entry table.
// Depends on rete_pkg for the field widths.
`timescale 1ns / 1ps

interface rete_req_if import rete_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic                auto_id;
  logic [KEY_W-1:0]    entry_id;
  logic [ADDR_W-1:0]   dest_addr;
  logic [PLEN_W-1:0]   prefix_len;
  logic [ADDR_W-1:0]   gateway_addr;
  logic [IFACE_W-1:0]  out_iface;

  modport source (output valid, req_type, auto_id, entry_id, dest_addr, prefix_len,
                  gateway_addr, out_iface, input ready);
  modport sink   (input valid, req_type, auto_id, entry_id, dest_addr, prefix_len,
                  gateway_addr, out_iface, output ready);
endinterface

interface rete_rsp_if import rete_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    result_id;

  modport source (output valid, status, result_id, input ready);
  modport sink   (input valid, status, result_id, output ready);
endinterface

// ===== design/rete_scan.sv =====
// Accumulator for one pass over the slot tags: largest valid id, lowest free
// slot and lowest slot matching the key. Depends on rete_pkg.
`timescale 1ns / 1ps

module rete_scan import rete_pkg::*; #(
  parameter int NUM_SLOTS = 32,
  parameter int ID_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         tag_vld,
  input  logic [$clog2(NUM_SLOTS)-1:0] tag_idx,
  input  logic                         tag_valid,
  input  logic [ID_BITS-1:0]           tag_id,
  input  logic [ID_BITS-1:0]           key,
  output logic [ID_BITS-1:0]           top_id,
  output logic [$clog2(NUM_SLOTS)-1:0] free_idx,
  output logic [$clog2(NUM_SLOTS)-1:0] hit_idx,
  output scan_flags_t                  flags
);

  localparam int AW = $clog2(NUM_SLOTS);

  logic [ID_BITS-1:0] top_r, top_nxt;
  logic [AW-1:0]      free_idx_r, free_idx_nxt;
  logic [AW-1:0]      hit_idx_r, hit_idx_nxt;
  scan_flags_t        flags_r, flags_nxt;

  always_comb begin
    top_nxt      = top_r;
    free_idx_nxt = free_idx_r;
    hit_idx_nxt  = hit_idx_r;
    flags_nxt    = flags_r;
    if (start) begin
      top_nxt   = '0;
      flags_nxt = '0;
    end else if (tag_vld) begin
      if (tag_valid && (tag_id > top_r)) begin
        top_nxt = tag_id;
      end
      // Slots arrive in ascending order, so the first hit is the lowest one.
      if (!tag_valid && !flags_r.free_found) begin
        flags_nxt.free_found = 1'b1;
        free_idx_nxt         = tag_idx;
      end
      if (tag_valid && (tag_id == key) && !flags_r.hit_found) begin
        flags_nxt.hit_found = 1'b1;
        hit_idx_nxt         = tag_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      top_r   <= '0;
    end else begin
      flags_r <= flags_nxt;
      top_r   <= top_nxt;
    end
    free_idx_r <= free_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
  end

  assign top_id   = top_r;
  assign free_idx = free_idx_r;
  assign hit_idx  = hit_idx_r;
  assign flags    = flags_r;

endmodule

// ===== design/route_entry_table_unit.sv =====
// Top level of the route entry table: tag and payload memories, request
// sequencer and response register. Depends on rete_pkg, rete_if and rete_scan.
//
//   channel   direction  handshake       contents
//   in_req    in         valid / ready   req_type, auto_id, entry_id, route payload
//   out_rsp   out        valid / ready   status, result_id
//
// A request reads the tag memory one slot per cycle through a registered read
// port, then the S_DONE state decides and writes back. After reset a clearing
// pass zeroes the valid marks; no request is taken during it. Requests are
// handled one at a time; the next one is taken while a response waits in the
// output register, and the write-back holds until that register is free.
`timescale 1ns / 1ps

module route_entry_table_unit import rete_pkg::*; #(
  parameter int NUM_SLOTS = 32,
  parameter int ID_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rete_req_if.sink    in_req,
  rete_rsp_if.source  out_rsp
);

  `include "route_entry_table_unit_macros.svh"

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [ID_BITS-1:0] ID_MAX = '1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Latched request.
  logic [REQ_W-1:0]   req_type_r;
  logic               auto_r;
  logic [ID_BITS-1:0] key_r;
  logic [PAY_W-1:0]   pay_r;

  // Memories: tag holds {valid, id}, payload holds the route fields.
  logic [ID_BITS:0]   tag_mem [NUM_SLOTS];
  logic [PAY_W-1:0]   pay_mem [NUM_SLOTS];
  logic [ID_BITS:0]   tag_rd_r;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               rd_vld_r;
  logic [AW-1:0]      rd_idx_r;

  logic               tag_we;
  logic [AW-1:0]      tag_wa;
  logic [ID_BITS:0]   tag_wd;
  logic               pay_we;

  // Scan results.
  logic [ID_BITS-1:0] top_id;
  logic [AW-1:0]      free_idx;
  logic [AW-1:0]      hit_idx;
  scan_flags_t        flags;

  // Response register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [KEY_W-1:0]    out_rid_r;

  logic                accept;
  logic                done_fire;
  logic [STATUS_W-1:0] dec_status;
  logic [ID_BITS-1:0]  dec_rid;
  logic [ID_BITS-1:0]  new_id;

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign done_fire    = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);
  assign rd_en        = (state_r == S_SCAN) && (cnt_r < CW'(NUM_SLOTS));
  assign rd_addr      = cnt_r[AW-1:0];

  rete_scan #(
    .NUM_SLOTS (NUM_SLOTS),
    .ID_BITS   (ID_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .tag_vld   (rd_vld_r),
    .tag_idx   (rd_idx_r),
    .tag_valid (tag_rd_r[ID_BITS]),
    .tag_id    (tag_rd_r[ID_BITS-1:0]),
    .key       (key_r),
    .top_id    (top_id),
    .free_idx  (free_idx),
    .hit_idx   (hit_idx),
    .flags     (flags)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Decision and write-back. Writes only happen after the scan has drained,
  // so the next request never reads an entry that is still being written.
  always_comb begin
    new_id     = top_id + 1'b1;
    dec_status = ST_OK;
    dec_rid    = key_r;
    tag_we     = 1'b0;
    tag_wa     = free_idx;
    tag_wd     = {1'b1, key_r};
    pay_we     = 1'b0;
    unique case (req_type_r)
      REQ_CREATE: begin
        if (auto_r && (top_id == ID_MAX)) begin
          dec_status = ST_EXHAUSTED;
          dec_rid    = '0;
        end else begin
          if (auto_r) begin
            dec_rid = new_id;
          end
          tag_wd = {1'b1, dec_rid};
          if (!flags.free_found) begin
            dec_status = ST_FULL;
          end else begin
            tag_we = done_fire;
            pay_we = done_fire;
          end
        end
      end
      REQ_UPDATE: begin
        tag_wa = hit_idx;
        if (!flags.hit_found) begin
          dec_status = ST_NOT_FOUND;
        end else begin
          tag_we = done_fire;
          pay_we = done_fire;
        end
      end
      REQ_DELETE: begin
        tag_wa = hit_idx;
        tag_wd = {1'b0, key_r};
        if (!flags.hit_found) begin
          dec_status = ST_NOT_FOUND;
        end else begin
          tag_we = done_fire;
        end
      end
      default: begin
        dec_status = ST_UNKNOWN;
        dec_rid    = '0;
      end
    endcase
    if (state_r == S_CLEAR) begin
      tag_we = 1'b1;
      tag_wa = cnt_r[AW-1:0];
      tag_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (pay_we) begin
      pay_mem[tag_wa] <= pay_r;
    end
    if (rd_en) begin
      tag_rd_r <= tag_mem[rd_addr];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (done_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r <= rd_addr;
    if (accept) begin
      req_type_r <= in_req.req_type;
      auto_r     <= in_req.auto_id;
      key_r      <= ID_BITS'(in_req.entry_id);
      pay_r      <= {in_req.dest_addr, in_req.gateway_addr, in_req.prefix_len,
                     in_req.out_iface};
    end
    if (done_fire) begin
      out_status_r <= dec_status;
      out_rid_r    <= KEY_W'(dec_rid);
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.result_id = out_rid_r;

  `RETE_ASSERT(a_no_write_in_scan, !((state_r == S_SCAN) && tag_we), "tag write during scan")
  `RETE_ASSERT(a_rd_in_scan, !rd_vld_r || (state_r == S_SCAN), "tag data outside scan")
  `RETE_ASSERT(a_unknown_rid, !(out_rsp.valid && (out_rsp.status == ST_UNKNOWN)) || (out_rsp.result_id == '0), "unknown request with nonzero id")
  `RETE_ASSERT_NEXT(a_done_to_idle, done_fire, (state_r == S_IDLE) && out_valid_r, "write-back did not publish response")

endmodule
